>>> rtl/wwkm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wwkm_pkg
// Shared types, constants and byte helpers for the keyword line matcher.
// ============================================================================
package wwkm_pkg;

    localparam int KEY_REGS = 4;
    localparam int KW_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int TLEN_W   = 4;
    localparam int KIDX_W   = 2;
    localparam int CNT_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_COMMA  = 8'h2c;
    localparam logic [7:0] CHAR_PERIOD = 8'h2e;
    localparam logic [7:0] CHAR_LBRACK = 8'h5b;
    localparam logic [7:0] CHAR_RBRACK = 8'h5d;
    localparam logic [7:0] CHAR_LBRACE = 8'h7b;
    localparam logic [7:0] CHAR_RBRACE = 8'h7d;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_SEMI   = 8'h3b;
    localparam logic [7:0] CHAR_APOS   = 8'h27;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // per-byte control broadcast to every cell
    typedef struct packed {
        logic              accept;
        logic              delim;
        logic              clear;
        logic              check;
        logic [7:0]        ch;
        logic [TLEN_W-1:0] pos;
        logic [TLEN_W-1:0] len_after;
    } wwkm_ctl_t;

    // priority link between neighboring cells
    typedef struct packed {
        logic              found;
        logic [KIDX_W-1:0] index;
    } wwkm_link_t;

    typedef struct packed {
        logic [CNT_W-1:0]  line_number;
        logic [CNT_W-1:0]  line_start_offset;
        logic [KIDX_W-1:0] keyword_index;
    } wwkm_result_t;

    function automatic logic is_delim(input logic [7:0] c);
        logic d;
        case (c)
            CHAR_SPACE, CHAR_CR, CHAR_LF, CHAR_COMMA, CHAR_PERIOD,
            CHAR_LBRACK, CHAR_RBRACK, CHAR_LBRACE, CHAR_RBRACE,
            CHAR_LPAREN, CHAR_RPAREN, CHAR_COLON, CHAR_SEMI, CHAR_APOS: d = 1'b1;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> rtl/wwkm_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// wwkm_cell
// One keyword slot: holds the keyword, its length and enable, tracks whether
// the token so far still equals it, and joins the lowest-index priority chain.
// ============================================================================
module wwkm_cell
    import wwkm_pkg::*;
#(
    parameter int KEY_CHARS = 8,
    parameter int CELL_ID   = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             key_we,
    input  logic             en_we,
    input  logic [KW_W-1:0]  cfg_data,
    input  wwkm_ctl_t        ctl,
    input  wwkm_link_t       link_in,
    output wwkm_link_t       link_out
);

    logic [KEY_CHARS-1:0][7:0] key_reg;
    logic [TLEN_W-1:0]         len_reg;
    logic                      en_reg;
    logic                      match_reg;
    logic                      match_next;

    logic [TLEN_W-1:0] len_calc;
    logic              len_stop;
    logic              byte_eq;
    logic              match_after;
    logic              hit;

    // keyword length: leading nonzero bytes
    always_comb
    begin
        len_calc = '0;
        len_stop = 1'b0;
        for (int b = 0; b < KEY_CHARS; b++)
        begin
            if (!len_stop && cfg_data[8*b +: 8] != 8'h00)
            begin
                len_calc = len_calc + 1'b1;
            end
            else
            begin
                len_stop = 1'b1;
            end
        end
    end

    always_comb
    begin
        byte_eq = 1'b0;
        for (int b = 0; b < KEY_CHARS; b++)
        begin
            if (ctl.pos == TLEN_W'(b) && key_reg[b] == ctl.ch)
            begin
                byte_eq = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (ctl.delim)
        begin
            match_after = match_reg;
        end
        else if (ctl.pos < TLEN_W'(KEY_CHARS))
        begin
            match_after = match_reg & byte_eq;
        end
        else
        begin
            match_after = 1'b0;
        end
        hit = ctl.check && en_reg && match_after && len_reg != '0
              && ctl.len_after == len_reg;
        match_next = ctl.clear ? 1'b1 : match_after;
    end

    always_comb
    begin
        link_out.found = link_in.found | hit;
        link_out.index = (hit && !link_in.found) ? KIDX_W'(CELL_ID) : link_in.index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            len_reg   <= '0;
            en_reg    <= 1'b0;
            match_reg <= 1'b1;
        end
        else
        begin
            if (key_we)
            begin
                key_reg <= cfg_data[KEY_CHARS*8-1:0];
                len_reg <= len_calc;
            end
            if (en_we)
            begin
                en_reg <= cfg_data[CELL_ID];
            end
            if (ctl.accept)
            begin
                match_reg <= match_next;
            end
        end
    end

endmodule

>>> rtl/wwkm_out_buf.sv
`timescale 1ns / 1ps
// ============================================================================
// wwkm_out_buf
// Two-entry result buffer: output register plus skid register.
// ============================================================================
module wwkm_out_buf
    import wwkm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  wwkm_result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_ready,
    output wwkm_result_t out_data
);

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    wwkm_result_t out_data_reg;
    wwkm_result_t out_data_next;
    wwkm_result_t skid_data_reg;
    wwkm_result_t skid_data_next;
    logic         pop;

    assign pop       = out_valid_reg & out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> rtl/whole_word_keyword_line_matcher.sv
`timescale 1ns / 1ps
// ============================================================================
// whole_word_keyword_line_matcher
// Case-insensitive whole-word keyword search, first match per line reported.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready) carries one text byte per item with
//   end_of_data marking the last byte of the stream.
//   match channel (match_valid/match_ready) carries line_number,
//   line_start_offset and keyword_index for the first match on each line.
//   cfg channel (cfg_valid/cfg_ready, always ready) writes keyword_0..3 at
//   index 0..3 and keyword_enable at index 4; write only while idle.
// Throughput: one byte per cycle while item_ready is high; every keyword
//   cell compares the byte in the same cycle and passes its hit down
//   the priority chain. A match is written into the output buffer when
//   the byte that ends the token is taken.
// Reset: keywords and enables clear, line counter restarts at one, byte
//   offset at zero; the block is ready right after reset.
// Stall: two results can wait in the output buffer; item_ready drops only
//   while both entries are full.
// ============================================================================
module whole_word_keyword_line_matcher
    import wwkm_pkg::*;
#(
    parameter int NUM_KEYS  = 4,
    parameter int KEY_CHARS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KW_W-1:0]      cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_data,
    output logic                 match_valid,
    input  logic                 match_ready,
    output logic [CNT_W-1:0]     line_number,
    output logic [CNT_W-1:0]     line_start_offset,
    output logic [KIDX_W-1:0]    keyword_index
);

    localparam int NCELL = (NUM_KEYS < KEY_REGS) ? NUM_KEYS : KEY_REGS;

    logic [TLEN_W-1:0] token_length_reg;
    logic [TLEN_W-1:0] token_length_next;
    logic              line_reported_reg;
    logic              line_reported_next;
    logic [CNT_W-1:0]  line_count_reg;
    logic [CNT_W-1:0]  line_count_next;
    logic [CNT_W-1:0]  byte_count_reg;
    logic [CNT_W-1:0]  byte_count_next;
    logic [CNT_W-1:0]  line_start_reg;
    logic [CNT_W-1:0]  line_start_next;

    logic              accept;
    logic              buf_full;
    logic              newline;
    logic              push;
    wwkm_ctl_t         ctl;
    wwkm_link_t        link [NCELL+1];
    wwkm_result_t      push_data;
    wwkm_result_t      out_data;

    assign cfg_ready  = 1'b1;
    assign item_ready = !buf_full;
    assign accept     = item_valid & item_ready;

    always_comb
    begin
        ctl.accept = accept;
        ctl.delim  = is_delim(data_byte);
        ctl.clear  = ctl.delim | end_of_data;
        ctl.ch     = fold_lower(data_byte);
        ctl.pos    = token_length_reg;
        if (ctl.delim)
        begin
            ctl.len_after = token_length_reg;
        end
        else if (token_length_reg < TLEN_W'(KEY_CHARS))
        begin
            ctl.len_after = token_length_reg + 1'b1;
        end
        else
        begin
            ctl.len_after = TLEN_W'(KEY_CHARS + 1);
        end
        ctl.check = ctl.clear && ctl.len_after != '0 && !line_reported_reg;
    end

    assign link[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            wwkm_cell #(
                .KEY_CHARS (KEY_CHARS),
                .CELL_ID   (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .key_we   (cfg_valid && cfg_index == CFG_IDX_W'(gi)),
                .en_we    (cfg_valid && cfg_index == REG_ENABLE),
                .cfg_data (cfg_data),
                .ctl      (ctl),
                .link_in  (link[gi]),
                .link_out (link[gi+1])
            );
        end
    endgenerate

    assign newline = (data_byte == CHAR_LF);
    assign push    = accept & link[NCELL].found;

    always_comb
    begin
        push_data.line_number       = line_count_reg;
        push_data.line_start_offset = line_start_reg;
        push_data.keyword_index     = link[NCELL].index;
    end

    always_comb
    begin
        token_length_next  = token_length_reg;
        line_reported_next = line_reported_reg;
        line_count_next    = line_count_reg;
        byte_count_next    = byte_count_reg;
        line_start_next    = line_start_reg;
        if (accept)
        begin
            token_length_next = ctl.clear ? '0 : ctl.len_after;
            byte_count_next   = byte_count_reg + 1'b1;
            if (push)
            begin
                line_reported_next = 1'b1;
            end
            if (newline)
            begin
                line_count_next    = line_count_reg + 1'b1;
                line_start_next    = byte_count_reg + 1'b1;
                line_reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_length_reg  <= '0;
            line_reported_reg <= 1'b0;
            line_count_reg    <= CNT_W'(1);
            byte_count_reg    <= '0;
            line_start_reg    <= '0;
        end
        else
        begin
            token_length_reg  <= token_length_next;
            line_reported_reg <= line_reported_next;
            line_count_reg    <= line_count_next;
            byte_count_reg    <= byte_count_next;
            line_start_reg    <= line_start_next;
        end
    end

    wwkm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (match_valid),
        .out_ready (match_ready),
        .out_data  (out_data)
    );

    assign line_number       = out_data.line_number;
    assign line_start_offset = out_data.line_start_offset;
    assign keyword_index     = out_data.keyword_index;

    // one report per line
    a_single_report: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !line_reported_reg)
        else $error("second match reported on one line");

    a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && newline) |=> !line_reported_reg)
        else $error("line flag not cleared after newline");

    a_token_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        token_length_reg <= TLEN_W'(KEY_CHARS + 1))
        else $error("token length beyond saturation");

    a_token_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctl.clear) |=> token_length_reg == '0)
        else $error("token not cleared at token end");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the whole-word keyword line matcher against a software model of
// the tokenizer and line tracker. Text bytes are streamed through the item
// channel with random gaps and output back-pressure; each first match on a
// line is predicted and compared field by field with the match channel.
// ============================================================================
module testbench;
    import wwkm_pkg::*;

    localparam int NUM_KEYS     = 4;
    localparam int KEY_CHARS    = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BYTES = 120;
    localparam int TIMEOUT_NS   = 2000000;
    localparam int MAX_PRINTS   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } text_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KW_W-1:0]      cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [7:0]           data_byte = '0;
    logic                 end_of_data = 1'b0;
    logic                 match_valid;
    logic                 match_ready = 1'b0;
    logic [CNT_W-1:0]     line_number;
    logic [CNT_W-1:0]     line_start_offset;
    logic [KIDX_W-1:0]    keyword_index;

    // shadow of the block's registers and state
    logic [KW_W-1:0]     key_reg [KEY_REGS];
    logic [3:0]          key_en = '0;
    logic [NUM_KEYS-1:0] live = '1;
    logic [3:0]          tok_len = '0;
    logic                line_done = 1'b0;
    logic [CNT_W-1:0]    line_cnt = 32'd1;
    logic [CNT_W-1:0]    byte_cnt = '0;
    logic [CNT_W-1:0]    line_start = '0;

    text_item_t   pending[$];
    wwkm_result_t match_q[$];

    logic item_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int   gap_left = 0;
    int   ready_gap = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    logic steady = 1'b0;

    int fail_count = 0;
    int queued_bytes = 0;
    int matches_seen = 0;
    int input_stalls = 0;
    int cfg_writes = 0;

    whole_word_keyword_line_matcher #(
        .NUM_KEYS  (NUM_KEYS),
        .KEY_CHARS (KEY_CHARS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .data_byte         (data_byte),
        .end_of_data       (end_of_data),
        .match_valid       (match_valid),
        .match_ready       (match_ready),
        .line_number       (line_number),
        .line_start_offset (line_start_offset),
        .keyword_index     (keyword_index)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (fail_count < MAX_PRINTS)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic logic is_separator(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_CR, CHAR_LF, CHAR_COMMA, CHAR_PERIOD,
                         CHAR_LBRACK, CHAR_RBRACK, CHAR_LBRACE, CHAR_RBRACE,
                         CHAR_LPAREN, CHAR_RPAREN, CHAR_COLON, CHAR_SEMI, CHAR_APOS};
    endfunction

    function automatic int key_len(input int k);
        int n;
        n = 0;
        while (n < KEY_CHARS && key_reg[k][8*n +: 8] != 8'h00)
        begin
            n++;
        end
        return n;
    endfunction

    // token end: first enabled keyword of equal length that still agrees
    task automatic close_token();
        wwkm_result_t hit;
        int k;
        if (tok_len != 0 && !line_done)
        begin
            for (k = 0; k < NUM_KEYS; k++)
            begin
                if (key_en[k] && live[k] && key_len(k) != 0 && tok_len == key_len(k))
                begin
                    hit.line_number       = line_cnt;
                    hit.line_start_offset = line_start;
                    hit.keyword_index     = KIDX_W'(k);
                    match_q.push_back(hit);
                    line_done = 1'b1;
                    break;
                end
            end
        end
        live    = '1;
        tok_len = '0;
    endtask

    task automatic track_byte(input logic [7:0] raw, input logic last);
        logic [7:0] c;
        int k;
        c = raw;
        if (is_separator(c))
        begin
            close_token();
            if (c == CHAR_LF)
            begin
                line_cnt   = line_cnt + 1;
                line_start = byte_cnt + 1;
                line_done  = 1'b0;
            end
        end
        else
        begin
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                c = c + CASE_OFFSET;
            end
            if (tok_len < KEY_CHARS)
            begin
                for (k = 0; k < NUM_KEYS; k++)
                begin
                    if (key_reg[k][8*tok_len +: 8] != c)
                    begin
                        live[k] = 1'b0;
                    end
                end
                tok_len = 4'(tok_len + 1);
            end
            else
            begin
                tok_len = 4'(KEY_CHARS + 1);
                live    = '0;
            end
            if (last)
            begin
                close_token();
            end
        end
        if (last)
        begin
            live    = '1;
            tok_len = '0;
        end
        byte_cnt = byte_cnt + 1;
    endtask

    // posedge: handshakes, prediction, result check
    always @(posedge clk)
    begin : watch
        wwkm_result_t want;
        if (!rst_n)
        begin
            item_taken <= 1'b0;
            cfg_taken  <= 1'b0;
        end
        else
        begin
            item_taken <= item_valid && item_ready;
            cfg_taken  <= cfg_valid && cfg_ready;
            if (item_valid && !item_ready)
            begin
                input_stalls++;
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                if (cfg_index < REG_ENABLE)
                begin
                    key_reg[cfg_index[1:0]] = cfg_data;
                end
                else if (cfg_index == REG_ENABLE)
                begin
                    key_en = cfg_data[3:0];
                end
            end
            if (item_valid && item_ready)
            begin
                track_byte(data_byte, end_of_data);
            end
            if (match_valid && match_ready)
            begin
                matches_seen++;
                if (match_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected match line %0d offset %0d key %0d",
                                         line_number, line_start_offset, keyword_index));
                end
                else
                begin
                    want = match_q.pop_front();
                    if (line_number !== want.line_number)
                    begin
                        flag_error($sformatf("line_number %0d, expected %0d",
                                             line_number, want.line_number));
                    end
                    if (line_start_offset !== want.line_start_offset)
                    begin
                        flag_error($sformatf("line_start_offset %0d, expected %0d",
                                             line_start_offset, want.line_start_offset));
                    end
                    if (keyword_index !== want.keyword_index)
                    begin
                        flag_error($sformatf("keyword_index %0d, expected %0d (line %0d)",
                                             keyword_index, want.keyword_index,
                                             want.line_number));
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // text byte driver
    always @(negedge clk)
    begin : drive_items
        text_item_t nxt;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            gap_left   <= 0;
        end
        else if (!item_valid || item_taken)
        begin
            if (gap_left != 0)
            begin
                item_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (pending.size() != 0)
            begin
                nxt = pending.pop_front();
                item_valid  <= 1'b1;
                data_byte   <= nxt.value;
                end_of_data <= nxt.last;
                gap_left    <= pick_gap();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // match receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            match_ready <= 1'b0;
            ready_gap   <= 0;
            hold_left   <= 0;
        end
        else if (hold_left != 0)
        begin
            match_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            match_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end
        else if (ready_gap != 0)
        begin
            match_ready <= 1'b0;
            ready_gap   <= ready_gap - 1;
        end
        else
        begin
            match_ready <= 1'b1;
            ready_gap   <= pick_gap();
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KW_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_keys(input logic [KW_W-1:0] k0, input logic [KW_W-1:0] k1,
                              input logic [KW_W-1:0] k2, input logic [KW_W-1:0] k3,
                              input logic [3:0] en);
        write_reg(REG_KEY0,   k0);
        write_reg(REG_KEY1,   k1);
        write_reg(REG_KEY2,   k2);
        write_reg(REG_KEY3,   k3);
        write_reg(REG_ENABLE, KW_W'(en));
    endtask

    function automatic logic [KW_W-1:0] pack_word(input string s);
        logic [KW_W-1:0] w;
        int i;
        w = '0;
        for (i = 0; i < s.len() && i < KEY_CHARS; i++)
        begin
            w[8*i +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'("a" + $urandom_range(0, 3));
    endfunction

    function automatic logic [KW_W-1:0] rand_word();
        logic [KW_W-1:0] w;
        int i;
        int n;
        w = '0;
        n = $urandom_range(1, KEY_CHARS);
        for (i = 0; i < n; i++)
        begin
            w[8*i +: 8] = rand_letter();
        end
        return w;
    endfunction

    task automatic push_item(input logic [7:0] value, input logic last);
        text_item_t it;
        it.value = value;
        it.last  = last;
        pending.push_back(it);
        queued_bytes++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            push_item(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(0, 12))
            0:       return CHAR_CR;
            1:       return CHAR_COMMA;
            2:       return CHAR_PERIOD;
            3:       return CHAR_LBRACK;
            4:       return CHAR_RBRACK;
            5:       return CHAR_LBRACE;
            6:       return CHAR_RBRACE;
            7:       return CHAR_LPAREN;
            8:       return CHAR_RPAREN;
            9:       return CHAR_COLON;
            10:      return CHAR_SEMI;
            11:      return CHAR_APOS;
            default: return CHAR_SPACE;
        endcase
    endfunction

    // keyword-like tokens mostly, plus near misses, overlong and raw bytes
    task automatic add_token();
        logic [7:0] bytes_q[$];
        logic [7:0] c;
        int kind;
        int k;
        int i;
        kind = $urandom_range(0, 9);
        k    = $urandom_range(0, NUM_KEYS - 1);
        if (kind <= 5)
        begin
            for (i = 0; i < key_len(k); i++)
            begin
                c = key_reg[k][8*i +: 8];
                if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                begin
                    c = c - CASE_OFFSET;
                end
                bytes_q.push_back(c);
            end
            if (kind == 5)
            begin
                bytes_q.push_back(rand_letter());
            end
        end
        else if (kind == 6)
        begin
            repeat ($urandom_range(KEY_CHARS + 1, KEY_CHARS + 4)) bytes_q.push_back(rand_letter());
        end
        else if (kind == 7)
        begin
            repeat ($urandom_range(1, 3)) bytes_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4)) bytes_q.push_back(rand_letter());
        end
        for (i = 0; i < bytes_q.size(); i++)
        begin
            push_item(bytes_q[i], i == bytes_q.size() - 1 && $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic add_line();
        int n;
        n = $urandom_range(1, 5);
        repeat (n)
        begin
            add_token();
            push_item(pick_sep(), $urandom_range(0, 19) == 0);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            push_item(CHAR_CR, 1'b0);
        end
        push_item(CHAR_LF, $urandom_range(0, 19) == 0);
    endtask

    task automatic add_random_lines(input int count);
        int start;
        start = queued_bytes;
        while (queued_bytes - start < count)
        begin
            add_line();
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk); while (pending.size() != 0 || item_valid);
        do @(negedge clk); while (match_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int spin;
        int k;
        for (k = 0; k < KEY_REGS; k++)
        begin
            key_reg[k] = '0;
        end
        repeat (14) @(negedge clk);

        // directed: case folding, repeat on a line, upper-case key, zero byte,
        // bytes after a zero in a key, eight-char key, end of data
        write_reg(REG_SPARE, '1);
        write_keys(pack_word("a"), pack_word("abcdefgh"), pack_word("Up"),
                   pack_word("ab") | (64'h7a7a << 24), 4'hf);
        @(posedge clk);
        push_text("A a\r\n");
        push_text("Up;");
        push_item("a", 1'b0);
        push_item(8'h00, 1'b0);
        push_item(CHAR_COMMA, 1'b0);
        push_item(8'hff, 1'b0);
        push_text("a;");
        push_text("AB\n");
        push_text("AbCdEfG");
        push_item("H", 1'b1);
        push_item(CHAR_SPACE, 1'b1);
        wait_idle();

        // random lines, one enabled keyword left empty
        write_keys(rand_word(), rand_word(), '0, rand_word(), 4'hf);
        @(posedge clk);
        add_random_lines(RANDOM_BYTES);
        wait_idle();

        // receiver holds off while matches keep coming
        write_keys(pack_word("x"), rand_word(), rand_word(), rand_word(), 4'b0001);
        @(posedge clk);
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (40) push_text("x\n");
        wait_idle();
        steady = 1'b0;

        // everything disabled, raw bytes
        write_reg(REG_ENABLE, '0);
        @(posedge clk);
        repeat (30) push_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        wait_idle();

        // all-ones key, shortest and longest keys, last slot disabled
        write_keys('1, pack_word("b"), pack_word("abcdabcd"), rand_word(), 4'b0111);
        @(posedge clk);
        steady = 1'b1;
        add_random_lines(RANDOM_BYTES / 2);
        do @(posedge clk); while (pending.size() != 0);
        steady = 1'b0;
        add_random_lines(RANDOM_BYTES / 2);

        do @(posedge clk); while (pending.size() != 0 || item_valid);
        spin = 0;
        while (match_q.size() != 0 && spin < 5000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (match_q.size() != 0)
        begin
            flag_error($sformatf("%0d expected matches never arrived", match_q.size()));
        end

        $display("run covered %0d text bytes, %0d matches, %0d register writes",
                 queued_bytes, matches_seen, cfg_writes);
        $display("input back-pressure seen on %0d cycles, %0d mismatches",
                 input_stalls, fail_count);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/wwkm_pkg.sv
rtl/wwkm_cell.sv
rtl/wwkm_out_buf.sv
rtl/whole_word_keyword_line_matcher.sv
tb/testbench.sv
